// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int Capacity   = 16;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int OccWidth   = 5;
   localparam int PrioWidth  = 8;
   localparam int TagWidth   = 16;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                 command;
      logic [PrioWidth-1:0] priority_req;
      logic [TagWidth-1:0]  tag;
   } req_type;

   typedef struct packed {
      logic                 out_valid;
      logic [PrioWidth-1:0] out_priority;
      logic [TagWidth-1:0]  out_tag;
      logic [1:0]           status;
      logic [OccWidth-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [PrioWidth-1:0] prio;
      logic [TagWidth-1:0]  tag;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      shift_in;
      logic      shift_out;
      entry_type item;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic               clock,
   input  wire spq_pkg::ctrl_type  ctrl,
   input  wire logic               occupied,
   input  wire logic               left_keep,
   input  wire spq_pkg::entry_type left_entry,
   input  wire spq_pkg::entry_type right_entry,
   output logic                    keep,
   output spq_pkg::entry_type      entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // hold the entry when it outranks or ties the incoming one
   assign keep = occupied && (entry_ff.prio >= ctrl.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_out) begin
         entry_in = right_entry;
      end else if (ctrl.shift_in && !keep) begin
         entry_in = left_keep ? ctrl.item : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                           Direction  Payload
// request   req_valid, req_stall, req_data  in         spq_pkg::req_type
// response  rsp_valid, rsp_stall, rsp_data  out        spq_pkg::rsp_type
//
// One request per cycle; its response is registered and appears in the
// cycle after acceptance. Every cell compares against the new priority in
// parallel and shifts with its neighbor on each insert or removal.
// Reset empties the queue and the response register; entry contents stay.
// A stalled response blocks new requests until it is taken.

module sorted_priority_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output spq_pkg::rsp_type      rsp_data
);

   localparam int N = spq_pkg::Capacity;

   logic [spq_pkg::CountWidth-1:0] count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic               accept, full, empty, do_enq, do_deq;
   spq_pkg::ctrl_type  ctrl;
   logic [N-1:0]       occupied;
   logic [N-1:0]       keep;
   spq_pkg::entry_type entries [N];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == spq_pkg::CountWidth'(N));
   assign empty     = (count_ff == '0);
   assign do_enq    = accept && (req_data.command == spq_pkg::CMD_ENQUEUE) && !full;
   assign do_deq    = accept && (req_data.command == spq_pkg::CMD_DEQUEUE) && !empty;

   assign ctrl.shift_in   = do_enq;
   assign ctrl.shift_out  = do_deq;
   assign ctrl.item.prio  = req_data.priority_req;
   assign ctrl.item.tag   = req_data.tag;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occupied[i] = (spq_pkg::CountWidth'(i) < count_ff);
      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[i]),
            .left_keep   (1'b1),
            .left_entry  (ctrl.item),
            .right_entry (entries[(i + 1) % N]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end else if (i == N - 1) begin : g_tail
         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (entries[i-1]),
            .right_entry (entries[i]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (entries[i-1]),
            .right_entry (entries[i+1]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_valid    = do_deq;
         rsp_data_in.out_priority = do_deq ? entries[0].prio : '0;
         rsp_data_in.out_tag      = do_deq ? entries[0].tag : '0;
         rsp_data_in.occupancy    = spq_pkg::OccWidth'(count_in);
         if (req_data.command == spq_pkg::CMD_ENQUEUE) begin
            rsp_data_in.status = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_DONE;
         end else begin
            rsp_data_in.status = empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_protocol_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire spq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire spq_pkg::rsp_type rsp_data
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // every accepted request yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // a returned entry always reports success
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> rsp_data.status == spq_pkg::STATUS_DONE)
      else $error("returned entry with failure status");

   // full rejection only at capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_FULL |->
         rsp_data.occupancy == spq_pkg::OccWidth'(spq_pkg::Capacity))
      else $error("full status below capacity");

   // empty dequeue leaves nothing and returns nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_EMPTY |->
         rsp_data.occupancy == '0 && !rsp_data.out_valid)
      else $error("empty status with entries or data");

endmodule

bind sorted_priority_queue spq_protocol_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
